[hdl/dbdq_pkg.sv]
package dbdq_pkg;

    // default ring depth
    localparam int DEPTH_DEF = 16;

    // operation requested by an input word
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_DROP_FRONT = 3'd2,
        KIND_DROP_BACK  = 3'd3,
        KIND_FIND       = 3'd4
    } kind_t;

    // outcome reported with each result word
    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

endpackage

[hdl/dbdq_mem.sv]
module dbdq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/dbdq_seq.sv]
module dbdq_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    // input side
    input  logic                in_valid,
    output logic                in_ready,
    input  dbdq_pkg::kind_t     in_kind,
    input  logic [31:0]         in_value,
    // result side
    output logic                res_valid,
    input  logic                res_take,
    output dbdq_pkg::status_t   res_status,
    output logic [CNT_W-1:0]    res_position,
    output logic [CNT_W-1:0]    res_occupancy,
    // storage ports
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [31:0]         wr_data,
    output logic [AW-1:0]       rd_addr,
    input  logic [31:0]         rd_data
);

    import dbdq_pkg::*;

    localparam int SW = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [AW-1:0]    front_reg, front_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      key_reg, key_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [AW-1:0]    front_dec;
    logic [AW-1:0]    front_inc;
    logic [AW-1:0]    slot_inc;
    logic [SW-1:0]    back_sum;
    logic [AW-1:0]    back_slot;
    logic             hit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign is_empty = (fill_reg == '0);

    // ring pointer arithmetic
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign slot_inc  = (slot_reg == AW'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign back_sum  = SW'(front_reg) + SW'(fill_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);

    // shared compare unit
    assign hit = (rd_data == key_reg);

    // read address runs one entry ahead of the compare
    assign rd_addr = (state_reg == ST_IDLE) ? front_reg : slot_inc;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = back_slot;
        wr_data     = in_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_DONE;
                    pos_next    = '0;
                    state_next  = ST_HOLD;
                    case (in_kind)
                        KIND_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                fill_next  = fill_reg + 1'b1;
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = back_slot;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        KIND_DROP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                fill_next  = fill_reg - 1'b1;
                            end
                        end
                        KIND_DROP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        KIND_FIND:
                        begin
                            key_next  = in_value;
                            slot_next = front_reg;
                            cnt_next  = '0;
                            if (is_empty)
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    status_next = STAT_DONE;
                    pos_next    = cnt_reg + 1'b1;
                    state_next  = ST_HOLD;
                end
                else if (cnt_reg + 1'b1 == fill_reg)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_HOLD;
                end
                else
                begin
                    slot_next = slot_inc;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            fill_reg  <= fill_next;
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        cnt_reg    <= cnt_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    assign res_valid     = (state_reg == ST_HOLD);
    assign res_status    = status_reg;
    assign res_position  = pos_reg;
    assign res_occupancy = fill_reg;

endmodule

[hdl/bounded_deque_with_search_core.sv]
// an accepted word yields a result in the sequencer hold state, which the
// output register then takes; a find first scans from the front entry until
// a hit or the last entry; a new word is taken once the last result is handed
// on; the scan reads and compares one entry per cycle via the single ram read port
// reset: rst_n clears the queue to empty with the front at slot 0, no result pending
module bounded_deque_with_search_core #(
    parameter int   DEPTH = dbdq_pkg::DEPTH_DEF,
    localparam int  AW    = $clog2(DEPTH),
    localparam int  CNT_W = $clog2(DEPTH + 1),
    localparam int  OUT_W = ((2 * CNT_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // value
    input  dbdq_pkg::kind_t    s_tuser,   // kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // position, occupancy, zero pad
    output dbdq_pkg::status_t  m_tuser    // status
);

    import dbdq_pkg::*;

    logic             res_valid;
    logic             res_take;
    status_t          res_status;
    logic [CNT_W-1:0] res_position;
    logic [CNT_W-1:0] res_occupancy;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [31:0]      wr_data;
    logic [AW-1:0]    rd_addr;
    logic [31:0]      rd_data;

    logic             m_tvalid_reg;
    status_t          status_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] occ_reg;

    // operation sequencer and compare unit
    dbdq_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_value      (s_tdata),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res_status    (res_status),
        .res_position  (res_position),
        .res_occupancy (res_occupancy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // ring storage
    dbdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg <= res_status;
            pos_reg    <= res_position;
            occ_reg    <= res_occupancy;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({occ_reg, pos_reg});

endmodule
